/* design/assert_macros.svh */
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property holds in the same cycle as its trigger.
`define ASSERT_NOW(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");

// Property holds in the cycle after its trigger.
`define ASSERT_NEXT(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");

`endif

/* design/latf_pkg.sv */
// Shared types and constants of the label area threshold filter.
package latf_pkg;

    localparam int LABELS     = 256;
    localparam int LABEL_W    = 8;
    localparam int AREA_W     = 48;
    localparam int SQRT_STEPS = 28;
    localparam int DIV_STEPS  = 52;
    localparam int CNT_W      = 6;

    // Item modes
    localparam logic [1:0] MODE_ACC  = 2'd0;
    localparam logic [1:0] MODE_FILT = 2'd1;
    localparam logic [1:0] MODE_CLR  = 2'd2;

    // Configuration register indexes
    localparam logic [2:0] CFG_CENTER_X  = 3'd0;
    localparam logic [2:0] CFG_CENTER_Y  = 3'd1;
    localparam logic [2:0] CFG_RADIUS    = 3'd2;
    localparam logic [2:0] CFG_PIX_AREA  = 3'd3;
    localparam logic [2:0] CFG_MIN_AREA  = 3'd4;
    localparam logic [2:0] CFG_REAL_MODE = 3'd5;

    // Controller to datapath
    typedef struct packed {
        logic load;
        logic clear;
        logic mul;
        logic cmp;
        logic sq_step;
        logic dv_step;
        logic rd;
        logic wr;
        logic out_load;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic [1:0] mode;
        logic       label_zero;
        logic       real_mode;
        logic       at_edge;
        logic       out_free;
    } t_sts;

endpackage

/* design/latf_ctrl.sv */
// Controller state machine of the label area threshold filter.
module latf_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  latf_pkg::t_sts  i_sts,
    output logic            o_in_stall,
    output latf_pkg::t_cmd  o_cmd
);

    typedef enum logic [8:0] {
        S_IDLE = 9'b000000001,
        S_DISP = 9'b000000010,
        S_MUL  = 9'b000000100,
        S_CMP  = 9'b000001000,
        S_SQRT = 9'b000010000,
        S_DIV  = 9'b000100000,
        S_READ = 9'b001000000,
        S_UPD  = 9'b010000000,
        S_OUT  = 9'b100000000
    } t_state;

    t_state r_state, n_state;
    logic [latf_pkg::CNT_W-1:0] r_cnt, n_cnt;

    assign o_in_stall = (r_state != S_IDLE);

    // Next state and commands
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DISP;
                end
            end
            S_DISP: begin
                case (i_sts.mode)
                    latf_pkg::MODE_CLR: begin
                        o_cmd.clear = 1'b1;
                        n_state     = S_IDLE;
                    end
                    latf_pkg::MODE_ACC: begin
                        if (i_sts.label_zero)
                            n_state = S_IDLE;
                        else if (i_sts.real_mode)
                            n_state = S_MUL;
                        else
                            n_state = S_READ;
                    end
                    latf_pkg::MODE_FILT: n_state = S_READ;
                    default:             n_state = S_IDLE;
                endcase
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_CMP;
            end
            S_CMP: begin
                o_cmd.cmp = 1'b1;
                n_cnt     = '0;
                n_state   = i_sts.at_edge ? S_READ : S_SQRT;
            end
            S_SQRT: begin
                o_cmd.sq_step = 1'b1;
                if (r_cnt == latf_pkg::CNT_W'(latf_pkg::SQRT_STEPS - 1)) begin
                    n_cnt   = '0;
                    n_state = S_DIV;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_DIV: begin
                o_cmd.dv_step = 1'b1;
                if (r_cnt == latf_pkg::CNT_W'(latf_pkg::DIV_STEPS - 1))
                    n_state = S_READ;
                else
                    n_cnt = r_cnt + 1'b1;
            end
            S_READ: begin
                o_cmd.rd = 1'b1;
                n_state  = S_UPD;
            end
            S_UPD: begin
                if (i_sts.mode == latf_pkg::MODE_ACC) begin
                    o_cmd.wr = 1'b1;
                    n_state  = S_IDLE;
                end else begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

endmodule

/* design/latf_dp.sv */
// Datapath: config registers, area arithmetic, region table and output beat.
module latf_dp (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  latf_pkg::t_cmd       i_cmd,
    output latf_pkg::t_sts       o_sts,
    input  logic                 i_cfg_we,
    input  logic [2:0]           i_cfg_idx,
    input  logic [47:0]          i_cfg_data,
    input  logic [1:0]           i_mode,
    input  logic [7:0]           i_label,
    input  logic [11:0]          i_col,
    input  logic [11:0]          i_row,
    input  logic                 i_out_stall,
    output logic                 o_out_valid,
    output logic [7:0]           o_label_out,
    output logic                 o_removed
);

    // Configuration
    logic [13:0] r_cx, r_cy;
    logic [19:0] r_radius;
    logic [23:0] r_parea;
    logic [47:0] r_min;
    logic        r_real;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cx     <= 14'd2048;
            r_cy     <= 14'd2048;
            r_radius <= '0;
            r_parea  <= 24'd65536;
            r_min    <= '0;
            r_real   <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                latf_pkg::CFG_CENTER_X:  r_cx     <= i_cfg_data[13:0];
                latf_pkg::CFG_CENTER_Y:  r_cy     <= i_cfg_data[13:0];
                latf_pkg::CFG_RADIUS:    r_radius <= i_cfg_data[19:0];
                latf_pkg::CFG_PIX_AREA:  r_parea  <= i_cfg_data[23:0];
                latf_pkg::CFG_MIN_AREA:  r_min    <= i_cfg_data;
                latf_pkg::CFG_REAL_MODE: r_real   <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Latched input beat
    logic [1:0]  r_mode;
    logic [7:0]  r_label;
    logic [11:0] r_col, r_row;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mode  <= i_mode;
            r_label <= i_label;
            r_col   <= i_col;
            r_row   <= i_row;
        end
    end

    // Squares and products
    logic signed [14:0] dx, dy;
    logic signed [29:0] dx_sq, dy_sq;
    logic [27:0] r_dx2, r_dy2;
    logic [39:0] r_r2;
    logic [43:0] r_num;

    assign dx    = $signed({3'b000, r_col}) - $signed({r_cx[13], r_cx});
    assign dy    = $signed({3'b000, r_row}) - $signed({r_cy[13], r_cy});
    assign dx_sq = dx * dx;
    assign dy_sq = dy * dy;

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul) begin
            r_dx2 <= dx_sq[27:0];
            r_dy2 <= dy_sq[27:0];
            r_r2  <= r_radius * r_radius;
            r_num <= r_radius * r_parea;
        end
    end

    // Distance against the disk edge
    logic [28:0] dist2;
    logic [44:0] dq;
    logic        at_edge;
    logic [39:0] d_diff;

    assign dist2   = {1'b0, r_dx2} + {1'b0, r_dy2};
    assign dq      = {dist2, 16'h0000};
    assign at_edge = ({5'b00000, r_r2} <= dq);
    assign d_diff  = r_r2 - dq[39:0];

    logic r_inf;
    always_ff @(posedge i_clk) begin
        if (i_cmd.load)
            r_inf <= 1'b0;
        else if (i_cmd.cmp)
            r_inf <= at_edge;
    end

    // Square root, two radicand bits a step
    logic [55:0] r_sq_src;
    logic [28:0] r_sq_rem;
    logic [27:0] r_sq_root;
    logic [30:0] sq_sh, sq_trial, sq_diff;
    logic        sq_ge;

    assign sq_sh    = {r_sq_rem, r_sq_src[55:54]};
    assign sq_trial = {1'b0, r_sq_root, 2'b01};
    assign sq_ge    = (sq_sh >= sq_trial);
    assign sq_diff  = sq_sh - sq_trial;

    always_ff @(posedge i_clk) begin
        if (i_cmd.cmp) begin
            r_sq_src  <= {d_diff, 16'h0000};
            r_sq_rem  <= '0;
            r_sq_root <= '0;
        end else if (i_cmd.sq_step) begin
            r_sq_src  <= {r_sq_src[53:0], 2'b00};
            r_sq_rem  <= sq_ge ? sq_diff[28:0] : sq_sh[28:0];
            r_sq_root <= {r_sq_root[26:0], sq_ge};
        end
    end

    // Restoring divider, one quotient bit a step
    logic [51:0] r_dv_q;
    logic [27:0] r_dv_rem;
    logic [28:0] dv_sh, dv_diff;
    logic        dv_ge;

    assign dv_sh   = {r_dv_rem, r_dv_q[51]};
    assign dv_ge   = (dv_sh >= {1'b0, r_sq_root});
    assign dv_diff = dv_sh - {1'b0, r_sq_root};

    always_ff @(posedge i_clk) begin
        if (i_cmd.cmp) begin
            r_dv_q   <= {r_num, 8'h00};
            r_dv_rem <= '0;
        end else if (i_cmd.dv_step) begin
            r_dv_q   <= {r_dv_q[50:0], dv_ge};
            r_dv_rem <= dv_ge ? dv_diff[27:0] : dv_sh[27:0];
        end
    end

    // Region table: area and infinite flag, valid bits give the cleared value
    logic [48:0] mem [latf_pkg::LABELS];
    logic        r_vld [latf_pkg::LABELS];
    logic [48:0] r_rd;
    logic        r_rd_vld;
    logic [48:0] entry, n_entry;
    logic [47:0] inc;
    logic [48:0] sum;

    assign entry = r_rd_vld ? r_rd : '0;
    assign inc   = r_real ? r_dv_q[47:0] : {24'h000000, r_parea};
    assign sum   = {1'b0, entry[47:0]} + {1'b0, inc};

    always_comb begin
        if (r_inf)
            n_entry = {1'b1, entry[47:0]};
        else
            n_entry = {entry[48], sum[48] ? {latf_pkg::AREA_W{1'b1}} : sum[47:0]};
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr)
            mem[r_label] <= n_entry;
        if (i_cmd.rd)
            r_rd <= mem[r_label];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clear) begin
            for (int i = 0; i < latf_pkg::LABELS; i++)
                r_vld[i] <= 1'b0;
        end else if (i_cmd.wr) begin
            r_vld[r_label] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd)
            r_rd_vld <= r_vld[r_label];
    end

    // Filter decision and output beat
    logic keep, out_free;
    logic r_out_valid;
    logic [7:0] r_label_out;
    logic r_removed;

    assign keep     = entry[48] || (entry[47:0] >= r_min);
    assign out_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_out_valid <= 1'b0;
        else if (i_cmd.out_load)
            r_out_valid <= 1'b1;
        else if (!i_out_stall)
            r_out_valid <= 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_label_out <= keep ? r_label : 8'h00;
            r_removed   <= (r_label != 8'h00) && !keep;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_label_out = r_label_out;
    assign o_removed   = r_removed;

    assign o_sts.mode       = r_mode;
    assign o_sts.label_zero = (r_label == 8'h00);
    assign o_sts.real_mode  = r_real;
    assign o_sts.at_edge    = at_edge;
    assign o_sts.out_free   = out_free;

endmodule

/* design/label_area_threshold_filter.sv */
// Top level of the label area threshold filter.
// Send the image twice: first with mode accumulate, then with mode filter; mode clear zeroes
// all region sums in one step. One item is worked at a time. An accumulate beat with
// projection-corrected area runs the 28-step square root and then the 52-step divider that
// the area path shares in sequence; a pixel at or beyond the disk edge skips both. A finished
// filter result waits in the output register while the next beat is taken.
module label_area_threshold_filter (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [47:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_mode,
    input  logic [7:0]  i_label,
    input  logic [11:0] i_col,
    input  logic [11:0] i_row,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [7:0]  o_label_out,
    output logic        o_removed
);

    latf_pkg::t_cmd cmd;
    latf_pkg::t_sts sts;

    latf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_sts      (sts),
        .o_in_stall (o_in_stall),
        .o_cmd      (cmd)
    );

    latf_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_mode      (i_mode),
        .i_label     (i_label),
        .i_col       (i_col),
        .i_row       (i_row),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_label_out (o_label_out),
        .o_removed   (o_removed)
    );

endmodule

/* design/latf_checker.sv */
// Port-level checker of the label area threshold filter and its bind.
`include "assert_macros.svh"

module latf_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_stall,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [7:0]  o_label_out,
    input logic        o_removed
);

    // A stalled result beat is held
    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid)

    // A removed region always answers label zero
    `ASSERT_NOW(a_removed_zero, i_clk, i_rst_n, o_out_valid && o_removed, o_label_out == 8'h00)

    // Each accepted beat keeps the block busy for at least the next cycle
    `ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_in_valid && !o_in_stall, o_in_stall)

    // A new result appears only out of a busy cycle
    `ASSERT_NOW(a_result_from_work, i_clk, i_rst_n, $rose(o_out_valid), $past(o_in_stall))

endmodule

bind label_area_threshold_filter latf_checker u_latf_checker (.*);

/* tb/tb_label_area_threshold_filter.sv */
// Self-checking testbench of the label area threshold filter, with its own area predictor.
module tb_label_area_threshold_filter;

    localparam logic [1:0] MODE_NONE  = 2'd3;   // reserved mode, dropped by the block
    localparam int         SETTLE     = 100;    // longest beat plus margin
    localparam int         WDOG_LIMIT = 3000;
    localparam logic [47:0] AREA_SAT  = 48'hFFFF_FFFF_FFFF;

    typedef struct packed {
        logic [7:0] label_out;
        logic       removed;
    } t_filt_result;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [2:0]  i_cfg_idx;
    logic [47:0] i_cfg_data;
    logic        i_in_valid;
    logic        o_in_stall;
    logic [1:0]  i_mode;
    logic [7:0]  i_label;
    logic [11:0] i_col;
    logic [11:0] i_row;
    logic        o_out_valid;
    logic        i_out_stall;
    logic [7:0]  o_label_out;
    logic        o_removed;

    label_area_threshold_filter dut (.*);

    // Predictor state
    logic [47:0]  area_sum [latf_pkg::LABELS];
    bit           inf_flag [latf_pkg::LABELS];
    longint       cen_x, cen_y;
    longint unsigned radius_q8, parea_q16, min_q16;
    bit           real_mode;
    t_filt_result filt_expect_q[$];

    int  err_cnt = 0;
    int  beat_cnt = 0;
    int  result_cnt = 0;
    int  wdog_cnt = 0;
    bit  idle_en = 1'b1;
    int  stall_left = 0;

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    task automatic report_mismatch(input string msg);
        begin
            $display("MISMATCH @%0t: %s", $time, msg);
            err_cnt++;
        end
    endtask

    function automatic longint unsigned int_sqrt(input longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        begin
            r = 0;
            b = 64'h1 << 62;
            while (b > v) b >>= 2;
            while (b != 0) begin
                if (v >= r + b) begin
                    v -= r + b;
                    r = (r >> 1) + b;
                end else begin
                    r >>= 1;
                end
                b >>= 2;
            end
            return r;
        end
    endfunction

    task automatic add_area(input int lbl, input longint unsigned inc);
        longint unsigned s;
        begin
            s = longint'(area_sum[lbl]) + inc;
            area_sum[lbl] = (s > longint'(AREA_SAT)) ? AREA_SAT : s[47:0];
        end
    endtask

    task automatic predictor_reset();
        begin
            cen_x = 2048;
            cen_y = 2048;
            radius_q8 = 0;
            parea_q16 = 65536;
            min_q16 = 0;
            real_mode = 1'b0;
            foreach (area_sum[i]) begin
                area_sum[i] = '0;
                inf_flag[i] = 1'b0;
            end
        end
    endtask

    // Update the predicted sums for one accepted beat and, for a filter beat, queue its answer
    task automatic predict_area(input logic [1:0] mode, input logic [7:0] lbl,
                                input logic [11:0] col, input logic [11:0] row);
        longint dx, dy;
        longint unsigned dist2, r2, dq, s, num;
        t_filt_result res;
        bit keep;
        begin
            case (mode)
                latf_pkg::MODE_CLR: begin
                    foreach (area_sum[i]) begin
                        area_sum[i] = '0;
                        inf_flag[i] = 1'b0;
                    end
                end
                latf_pkg::MODE_ACC: begin
                    if (lbl != 0) begin
                        if (!real_mode) begin
                            add_area(int'(lbl), parea_q16);
                        end else begin
                            dx = longint'(col) - cen_x;
                            dy = longint'(row) - cen_y;
                            dist2 = dx * dx + dy * dy;
                            r2 = radius_q8 * radius_q8;
                            dq = dist2 << 16;
                            if (r2 <= dq) begin
                                inf_flag[lbl] = 1'b1;
                            end else begin
                                s = int_sqrt((r2 - dq) << 16);
                                num = (radius_q8 * parea_q16) << 8;
                                add_area(int'(lbl), num / s);
                            end
                        end
                    end
                end
                latf_pkg::MODE_FILT: begin
                    keep = (lbl == 0) || inf_flag[lbl] || (longint'(area_sum[lbl]) >= min_q16);
                    res.label_out = keep ? lbl : 8'd0;
                    res.removed = !keep;
                    filt_expect_q.push_back(res);
                end
                default: ;
            endcase
        end
    endtask

    // Send one beat, with an optional idle burst first
    task automatic send_pixel(input logic [1:0] mode, input logic [7:0] lbl,
                              input logic [11:0] col, input logic [11:0] row);
        int gap;
        begin
            if (idle_en && $urandom_range(0, 3) == 0) begin
                gap = $urandom_range(1, 9);
                @(negedge i_clk);
                i_in_valid <= 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
            @(negedge i_clk);
            i_in_valid <= 1'b1;
            i_mode <= mode;
            i_label <= lbl;
            i_col <= col;
            i_row <= row;
            do @(posedge i_clk); while (o_in_stall);
            predict_area(mode, lbl, col, row);
            beat_cnt++;
            // the beat is taken: drop valid before the next edge
            @(negedge i_clk);
            i_in_valid <= 1'b0;
        end
    endtask

    // Let every result drain and the last beat finish
    task automatic wait_idle();
        begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
            while (filt_expect_q.size() != 0) @(posedge i_clk);
            repeat (SETTLE) @(posedge i_clk);
        end
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [47:0] data);
        begin
            @(negedge i_clk);
            i_cfg_we <= 1'b1;
            i_cfg_idx <= idx;
            i_cfg_data <= data;
            @(negedge i_clk);
            i_cfg_we <= 1'b0;
            case (idx)
                latf_pkg::CFG_CENTER_X:  cen_x = longint'($signed(data[13:0]));
                latf_pkg::CFG_CENTER_Y:  cen_y = longint'($signed(data[13:0]));
                latf_pkg::CFG_RADIUS:    radius_q8 = 64'(data[19:0]);
                latf_pkg::CFG_PIX_AREA:  parea_q16 = 64'(data[23:0]);
                latf_pkg::CFG_MIN_AREA:  min_q16 = 64'(data);
                latf_pkg::CFG_REAL_MODE: real_mode = data[0];
                default: ;
            endcase
        end
    endtask

    // Output stall bursts
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            stall_left--;
            i_out_stall <= 1'b1;
        end else if (idle_en && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(0, 8);
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    // Result checker
    always @(posedge i_clk) begin
        t_filt_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            result_cnt++;
            if (filt_expect_q.size() == 0) begin
                report_mismatch($sformatf("unexpected result label_out=%0d", o_label_out));
            end else begin
                want = filt_expect_q.pop_front();
                if (o_label_out !== want.label_out)
                    report_mismatch($sformatf("label_out %0d, expected %0d",
                                              o_label_out, want.label_out));
                if (o_removed !== want.removed)
                    report_mismatch($sformatf("removed %0b, expected %0b",
                                              o_removed, want.removed));
            end
        end
    end

    // Watchdog on cycles without any beat
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            wdog_cnt <= 0;
        end else if (wdog_cnt >= WDOG_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end else begin
            wdog_cnt <= wdog_cnt + 1;
        end
    end

    // Reset values, filter answers, label zero, reserved mode
    task automatic test_reset_defaults();
        begin
            send_pixel(latf_pkg::MODE_FILT, 8'd5, 12'd0, 12'd0);
            send_pixel(latf_pkg::MODE_FILT, 8'd0, 12'hFFF, 12'hFFF);
            send_pixel(latf_pkg::MODE_ACC, 8'd1, 12'd10, 12'd20);
            send_pixel(latf_pkg::MODE_ACC, 8'd255, 12'hFFF, 12'd0);
            send_pixel(latf_pkg::MODE_ACC, 8'd0, 12'd0, 12'hFFF);
            send_pixel(MODE_NONE, 8'd1, 12'd1, 12'd1);
            send_pixel(latf_pkg::MODE_FILT, 8'd1, 12'd0, 12'd0);
            send_pixel(latf_pkg::MODE_FILT, 8'd255, 12'd0, 12'd0);
            wait_idle();
        end
    endtask

    // Register extremes, infinite labels, clear
    task automatic test_config_extremes();
        begin
            write_reg(latf_pkg::CFG_MIN_AREA, 48'hFFFF_FFFF_FFFF);
            write_reg(latf_pkg::CFG_PIX_AREA, 48'h0);
            send_pixel(latf_pkg::MODE_ACC, 8'd2, 12'd0, 12'd0);
            send_pixel(latf_pkg::MODE_FILT, 8'd2, 12'd0, 12'd0);
            send_pixel(latf_pkg::MODE_FILT, 8'd0, 12'd0, 12'd0);
            wait_idle();
            write_reg(latf_pkg::CFG_CENTER_X, 48'h2000);
            write_reg(latf_pkg::CFG_CENTER_Y, 48'h1FFF);
            write_reg(latf_pkg::CFG_RADIUS, 48'h0);
            write_reg(latf_pkg::CFG_REAL_MODE, 48'h1);
            // zero radius: every pixel sits on the edge
            send_pixel(latf_pkg::MODE_ACC, 8'd3, 12'd0, 12'hFFF);
            send_pixel(latf_pkg::MODE_FILT, 8'd3, 12'd0, 12'd0);
            wait_idle();
            write_reg(latf_pkg::CFG_CENTER_X, 48'h0);
            write_reg(latf_pkg::CFG_CENTER_Y, 48'h0);
            write_reg(latf_pkg::CFG_RADIUS, 48'hFFFFF);
            write_reg(latf_pkg::CFG_PIX_AREA, 48'hFFFFFF);
            write_reg(latf_pkg::CFG_MIN_AREA, 48'h1);
            send_pixel(latf_pkg::MODE_ACC, 8'd4, 12'd0, 12'd0);
            send_pixel(latf_pkg::MODE_ACC, 8'd5, 12'hFFF, 12'hFFF);
            send_pixel(latf_pkg::MODE_FILT, 8'd4, 12'd0, 12'd0);
            send_pixel(latf_pkg::MODE_FILT, 8'd5, 12'd0, 12'd0);
            send_pixel(latf_pkg::MODE_CLR, 8'd0, 12'd0, 12'd0);
            send_pixel(latf_pkg::MODE_FILT, 8'd3, 12'd0, 12'd0);
            send_pixel(latf_pkg::MODE_FILT, 8'd4, 12'd0, 12'd0);
            wait_idle();
        end
    endtask

    // Sum saturation: d = 1 gives the largest real increment
    task automatic test_area_saturation();
        begin
            write_reg(latf_pkg::CFG_RADIUS, 48'd131073);
            write_reg(latf_pkg::CFG_MIN_AREA, 48'hFFFF_FFFF_FFFF);
            send_pixel(latf_pkg::MODE_FILT, 8'd9, 12'd0, 12'd0);
            for (int n = 0; n < 140; n++) begin
                send_pixel(latf_pkg::MODE_ACC, 8'd9, 12'd512, 12'd2);
                if (n == 60) send_pixel(latf_pkg::MODE_FILT, 8'd9, 12'd0, 12'd0);
            end
            send_pixel(latf_pkg::MODE_FILT, 8'd9, 12'd0, 12'd0);
            wait_idle();
        end
    endtask

    // Two-pass images under random settings
    task automatic test_random_images(input int phases);
        logic [7:0]  lbl_set [8];
        logic [7:0]  pix_lbl [48];
        logic [11:0] pix_col [48];
        logic [11:0] pix_row [48];
        logic [11:0] base_c, base_r;
        logic [7:0]  pick;
        logic [47:0] m;
        int npix;
        begin
            for (int ph = 0; ph < phases; ph++) begin
                if (ph >= phases - 2) idle_en = 1'b0;
                base_c = 12'($urandom_range(0, 4095 - 16));
                base_r = 12'($urandom_range(0, 4095 - 16));
                if ($urandom_range(0, 3) == 0) begin
                    write_reg(latf_pkg::CFG_CENTER_X, 48'({$urandom, $urandom}));
                    write_reg(latf_pkg::CFG_CENTER_Y, 48'({$urandom, $urandom}));
                    write_reg(latf_pkg::CFG_RADIUS, 48'({$urandom, $urandom}));
                end else begin
                    write_reg(latf_pkg::CFG_CENTER_X,
                              48'(base_c) + 48'($urandom_range(0, 16)));
                    write_reg(latf_pkg::CFG_CENTER_Y,
                              48'(base_r) + 48'($urandom_range(0, 16)));
                    write_reg(latf_pkg::CFG_RADIUS, 48'($urandom_range(0, 40 * 256)));
                end
                write_reg(latf_pkg::CFG_PIX_AREA,
                          ($urandom_range(0, 1) != 0) ? 48'({$urandom, $urandom})
                                                       : 48'd65536);
                write_reg(latf_pkg::CFG_REAL_MODE, 48'($urandom_range(0, 1)));
                foreach (lbl_set[i]) lbl_set[i] = (i == 0) ? 8'd0 : 8'($urandom);
                npix = $urandom_range(16, 48);
                for (int p = 0; p < npix; p++) begin
                    pix_lbl[p] = lbl_set[$urandom_range(0, 7)];
                    pix_col[p] = base_c + 12'($urandom_range(0, 15));
                    pix_row[p] = base_r + 12'($urandom_range(0, 15));
                end
                send_pixel(latf_pkg::MODE_CLR, 8'($urandom), 12'($urandom), 12'($urandom));
                // accumulate pass, with a little noise
                for (int p = 0; p < npix; p++) begin
                    if ($urandom_range(0, 19) == 0)
                        send_pixel(MODE_NONE, 8'($urandom), 12'($urandom), 12'($urandom));
                    send_pixel(latf_pkg::MODE_ACC, pix_lbl[p], pix_col[p], pix_row[p]);
                end
                wait_idle();
                // threshold near the sum of one label of this image, or random, or zero
                pick = lbl_set[$urandom_range(1, 7)];
                m = area_sum[pick];
                case ($urandom_range(0, 4))
                    0: write_reg(latf_pkg::CFG_MIN_AREA, m);
                    1: write_reg(latf_pkg::CFG_MIN_AREA, m + 48'd1);
                    2: write_reg(latf_pkg::CFG_MIN_AREA, (m == 0) ? m : m - 48'd1);
                    3: write_reg(latf_pkg::CFG_MIN_AREA, 48'({$urandom, $urandom}));
                    default: write_reg(latf_pkg::CFG_MIN_AREA, 48'd0);
                endcase
                // filter pass
                for (int p = 0; p < npix; p++) begin
                    if ($urandom_range(0, 9) == 0)
                        send_pixel(latf_pkg::MODE_FILT, 8'($urandom), 12'($urandom),
                                   12'($urandom));
                    send_pixel(latf_pkg::MODE_FILT, pix_lbl[p], pix_col[p], pix_row[p]);
                end
                wait_idle();
            end
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = '0;
        i_cfg_data = '0;
        i_in_valid = 1'b0;
        i_mode = latf_pkg::MODE_ACC;
        i_label = '0;
        i_col = '0;
        i_row = '0;
        i_out_stall = 1'b0;
        predictor_reset();
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_defaults();
        test_config_extremes();
        test_area_saturation();
        test_random_images(10);

        wait_idle();
        $display("Covered %0d input beats and checked %0d filter answers,", beat_cnt, result_cnt);
        $display("over raw and projected areas, infinite labels, clears and saturation.");
        if (err_cnt == 0 && filt_expect_q.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
